// File: src/tlbc_pkg.sv
// Shared types and constants of the TLB translation block with clock replacement.
// Used by every module in src but tlbc_ram; depends on nothing.
package tlbc_pkg;

  localparam int TLB_ENTRIES_DEF = 32;
  localparam int PAGE_COUNT_DEF  = 64;

  localparam int VA_W     = 16;
  localparam int PAGE_W   = 6;
  localparam int OFF_W    = 10;
  localparam int FRAME_W  = 14;
  localparam int PA_W     = 24;
  localparam int LIMIT_W  = 6;
  localparam int STATUS_W = 2;
  localparam int FLAGS_W  = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd8;

  // Flag positions inside a page table entry's flag nibble.
  localparam int FLG_VALID = 0;
  localparam int FLG_READ  = 1;
  localparam int FLG_WRITE = 2;
  localparam int FLG_EXEC  = 3;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PROT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SWEEP,
    ST_HIT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_INVALID,
    RES_PROT,
    RES_MISS,
    RES_HIT
  } res_kind_t;

  typedef struct packed {
    logic      capture;
    logic      lookup;
    logic      pt_write;
    logic      hit_touch;
    logic      fill_insert;
    logic      hand_norm;
    logic      sweep_step;
    logic      emit;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic any_hit;
    logic fault_invalid;
    logic fault_prot;
    logic lim_zero;
    logic tlb_full;
    logic sweep_found;
    logic out_free;
  } sts_t;

endpackage

// File: src/tlbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package needed.
module tlbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/tlbc_ctrl.sv
// Sequencer of the TLB translation block: walks one word through lookup or page table
// write, decision, clock sweep and result hand-off. Depends on tlbc_pkg.
module tlbc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tlbc_pkg::sts_t sts,
  output tlbc_pkg::cmd_t cmd
);
  import tlbc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = sts.is_write ? ST_EMIT : ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (sts.any_hit) state_nxt = ST_HIT;
        else if (sts.fault_invalid || sts.fault_prot || sts.lim_zero || !sts.tlb_full)
          state_nxt = ST_EMIT;
        else state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sts.sweep_found) state_nxt = ST_EMIT;
      end
      ST_HIT: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOKUP: begin
        if (sts.is_write) begin
          cmd.pt_write = 1'b1;
          cmd.res_kind = RES_ZERO;
        end else begin
          cmd.lookup = 1'b1;
        end
      end
      ST_DECIDE: begin
        priority if (sts.any_hit) cmd.hit_touch = 1'b1;
        else if (sts.fault_invalid) cmd.res_kind = RES_INVALID;
        else if (sts.fault_prot) cmd.res_kind = RES_PROT;
        else if (sts.lim_zero) cmd.res_kind = RES_MISS;
        else if (!sts.tlb_full) begin
          cmd.fill_insert = 1'b1;
          cmd.res_kind    = RES_MISS;
        end else cmd.hand_norm = 1'b1;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_found) cmd.res_kind = RES_MISS;
      end
      ST_HIT: begin
        cmd.res_kind = RES_HIT;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: src/tlbc_datapath.sv
// Datapath of the TLB translation block: TLB tags and use bits, page table, clock
// hand, result and output registers. Depends on tlbc_pkg and tlbc_ram.
module tlbc_datapath #(
  parameter int TLB_ENTRIES = tlbc_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = tlbc_pkg::PAGE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tlbc_pkg::cmd_t                 cmd,
  output tlbc_pkg::sts_t                 sts,
  input  logic                           in_mode,
  input  logic [tlbc_pkg::VA_W-1:0]      in_virtual_address,
  input  logic [tlbc_pkg::PAGE_W-1:0]    in_page_index,
  input  logic [tlbc_pkg::FRAME_W-1:0]   in_entry_frame,
  input  logic                           in_entry_valid,
  input  logic                           in_entry_read,
  input  logic                           in_entry_write,
  input  logic                           in_entry_execute,
  input  logic                           cfg_valid,
  input  logic [tlbc_pkg::LIMIT_W-1:0]   cfg_tlb_limit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tlbc_pkg::PA_W-1:0]      out_physical_address,
  output logic                           out_tlb_hit,
  output logic [tlbc_pkg::STATUS_W-1:0]  out_status
);
  import tlbc_pkg::*;

  localparam int IDX_W    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_W    = $clog2(TLB_ENTRIES + 1);
  localparam int LW       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  // Only pages reachable through the 6-bit page field need storage.
  localparam int PT_DEPTH = (PAGE_COUNT < (1 << PAGE_W)) ? PAGE_COUNT : (1 << PAGE_W);
  localparam int PT_AW    = $clog2(PT_DEPTH);
  localparam int PT_W     = FRAME_W + FLAGS_W;
  localparam int PW1      = PAGE_W + 1;

  // Captured word.
  logic                 mode_r;
  logic [VA_W-1:0]      va_r;
  logic [PAGE_W-1:0]    pidx_r;
  logic [FRAME_W-1:0]   efr_r;
  logic [FLAGS_W-1:0]   eflg_r;

  logic [LIMIT_W-1:0]   limit_r;
  logic [CNT_W-1:0]     filled_r;
  logic [IDX_W-1:0]     hand_r;
  logic [TLB_ENTRIES-1:0] use_r;
  logic [PAGE_W-1:0]    tlb_page_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] match_r, match_nxt;
  logic [PT_DEPTH-1:0]  pt_vld_r;
  logic                 ptq_vld_r;

  logic [PA_W-1:0]      res_pa_r;
  logic                 res_hit_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic                 out_valid_r;
  logic [PA_W-1:0]      out_pa_r;
  logic                 out_hit_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic [PAGE_W-1:0]    page;
  logic [OFF_W-1:0]     offset;
  logic [LW-1:0]        lim_ext;
  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     n_act;
  logic [IDX_W-1:0]     hit_idx;
  logic [CNT_W-1:0]     hand_inc;
  logic [IDX_W-1:0]     hand_adv;
  logic                 hand_out;
  logic                 ins_en;
  logic [IDX_W-1:0]     ins_slot;
  logic                 page_in_range;
  logic                 pidx_in_range;
  logic [PT_AW-1:0]     pt_raddr;
  logic [PT_AW-1:0]     pt_waddr;
  logic [PT_W-1:0]      pt_rdata;
  logic [FRAME_W-1:0]   tf_rdata;
  logic [FRAME_W-1:0]   pt_frame;
  logic [FLAGS_W-1:0]   pt_flags;

  assign page          = va_r[VA_W-1:OFF_W];
  assign offset        = va_r[OFF_W-1:0];
  assign lim_ext       = LW'(limit_r);
  assign lim           = (lim_ext > LW'(TLB_ENTRIES)) ? CNT_W'(TLB_ENTRIES) : CNT_W'(lim_ext);
  assign n_act         = (filled_r < lim) ? filled_r : lim;
  assign page_in_range = {1'b0, page} < PW1'(PT_DEPTH);
  assign pidx_in_range = {1'b0, pidx_r} < PW1'(PT_DEPTH);
  assign pt_raddr      = page[PT_AW-1:0];
  assign pt_waddr      = pidx_r[PT_AW-1:0];
  assign pt_frame      = pt_rdata[FRAME_W-1:0];
  assign pt_flags      = pt_rdata[PT_W-1:FRAME_W];

  assign hand_inc = CNT_W'(hand_r) + CNT_W'(1);
  assign hand_adv = (hand_inc >= lim) ? '0 : hand_inc[IDX_W-1:0];
  assign hand_out = CNT_W'(hand_r) >= lim;

  // A sweep step that finds a clear use bit claims that slot.
  assign ins_en   = cmd.fill_insert | (cmd.sweep_step & ~use_r[hand_r]);
  assign ins_slot = cmd.fill_insert ? filled_r[IDX_W-1:0] : hand_r;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_nxt[i] = (tlb_page_r[i] == page) && (CNT_W'(i) < n_act);
    end
  end

  // Lowest matching entry wins, since stale duplicates may sit above the limit.
  always_comb begin
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      va_r   <= in_virtual_address;
      pidx_r <= in_page_index;
      efr_r  <= in_entry_frame;
      eflg_r[FLG_VALID] <= in_entry_valid;
      eflg_r[FLG_READ]  <= in_entry_read;
      eflg_r[FLG_WRITE] <= in_entry_write;
      eflg_r[FLG_EXEC]  <= in_entry_execute;
    end
    if (cmd.lookup) begin
      match_r   <= match_nxt;
      ptq_vld_r <= page_in_range ? pt_vld_r[pt_raddr] : 1'b0;
    end
    if (ins_en) begin
      tlb_page_r[ins_slot] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      filled_r <= '0;
      hand_r   <= '0;
      use_r    <= '0;
      pt_vld_r <= '0;
    end else begin
      if (cfg_valid) limit_r <= cfg_tlb_limit;
      if (cmd.fill_insert) filled_r <= filled_r + CNT_W'(1);
      if (cmd.hand_norm && hand_out) hand_r <= '0;
      else if (cmd.sweep_step) hand_r <= hand_adv;
      if (cmd.hit_touch) use_r[hit_idx] <= 1'b1;
      if (ins_en) use_r[ins_slot] <= 1'b1;
      else if (cmd.sweep_step) use_r[hand_r] <= 1'b0;
      if (cmd.pt_write && pidx_in_range) pt_vld_r[pt_waddr] <= 1'b1;
    end
  end

  tlbc_ram #(
    .WIDTH(PT_W),
    .DEPTH(PT_DEPTH)
  ) u_page_table (
    .clk  (clk),
    .we   (cmd.pt_write & pidx_in_range),
    .waddr(pt_waddr),
    .wdata({eflg_r, efr_r}),
    .re   (cmd.lookup),
    .raddr(pt_raddr),
    .rdata(pt_rdata)
  );

  tlbc_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(TLB_ENTRIES)
  ) u_tlb_frame (
    .clk  (clk),
    .we   (ins_en),
    .waddr(ins_slot),
    .wdata(pt_frame),
    .re   (cmd.hit_touch),
    .raddr(hit_idx),
    .rdata(tf_rdata)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.res_kind)
      RES_NONE: begin
      end
      RES_ZERO: begin
        res_pa_r     <= '0;
        res_hit_r    <= 1'b0;
        res_status_r <= STAT_OK;
      end
      RES_INVALID: begin
        res_pa_r     <= '0;
        res_hit_r    <= 1'b0;
        res_status_r <= STAT_INVALID;
      end
      RES_PROT: begin
        res_pa_r     <= '0;
        res_hit_r    <= 1'b0;
        res_status_r <= STAT_PROT;
      end
      RES_MISS: begin
        res_pa_r     <= {pt_frame, offset};
        res_hit_r    <= 1'b0;
        res_status_r <= STAT_OK;
      end
      RES_HIT: begin
        res_pa_r     <= {tf_rdata, offset};
        res_hit_r    <= 1'b1;
        res_status_r <= STAT_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pa_r     <= res_pa_r;
      out_hit_r    <= res_hit_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.is_write      = mode_r;
  assign sts.any_hit       = |match_r;
  assign sts.fault_invalid = ~ptq_vld_r | ~pt_flags[FLG_VALID];
  assign sts.fault_prot    = ~(pt_flags[FLG_READ] | pt_flags[FLG_WRITE]);
  assign sts.lim_zero      = (lim == '0);
  assign sts.tlb_full      = (filled_r >= lim);
  assign sts.sweep_found   = ~use_r[hand_r];
  assign sts.out_free      = ~out_valid_r | out_ready;

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_status           = out_status_r;

endmodule

// File: src/tlb_clock_replacement_translate_top.sv
// Address translation with a fully associative TLB and clock replacement.
// Input words either translate a 16-bit virtual address (page 15..10, offset 9..0)
// or load one page table entry; every input word yields exactly one output word.
// Output: physical_address = frame:offset, tlb_hit, status (0 ok, 1 invalid page,
// 2 protection fault). Faults and page table loads return a zero address.
// The cfg channel writes tlb_limit (entries in use, 0 bypasses the TLB); it is
// always ready and should only be written while no word is in flight.
// One word is worked on at a time. A page table load is written and handed off;
// a miss that faults or fills a free slot passes the decision first; a TLB hit
// also reads the frame RAM; a miss into a full TLB also runs the clock sweep,
// clearing use bits one entry per cycle. out_valid and in_ready rise together.
// Hits pay for the registered match vector and the registered frame RAM read.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; if out_ready stays low, the following result is held
// inside and in_ready drops until the output register frees up.
// Reset (rst_n low at a clock edge) empties the TLB, clears all use bits, the clock
// hand and the page table valid bits, and sets tlb_limit to 8.
// Depends on tlbc_pkg, tlbc_ctrl, tlbc_datapath and tlbc_ram.
module tlb_clock_replacement_translate_top #(
  parameter int TLB_ENTRIES = tlbc_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = tlbc_pkg::PAGE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [tlbc_pkg::VA_W-1:0]      in_virtual_address,
  input  logic [tlbc_pkg::PAGE_W-1:0]    in_page_index,
  input  logic [tlbc_pkg::FRAME_W-1:0]   in_entry_frame,
  input  logic                           in_entry_valid,
  input  logic                           in_entry_read,
  input  logic                           in_entry_write,
  input  logic                           in_entry_execute,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tlbc_pkg::PA_W-1:0]      out_physical_address,
  output logic                           out_tlb_hit,
  output logic [tlbc_pkg::STATUS_W-1:0]  out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlbc_pkg::LIMIT_W-1:0]   cfg_tlb_limit
);
  import tlbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tlbc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tlbc_datapath #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_mode),
    .in_virtual_address  (in_virtual_address),
    .in_page_index       (in_page_index),
    .in_entry_frame      (in_entry_frame),
    .in_entry_valid      (in_entry_valid),
    .in_entry_read       (in_entry_read),
    .in_entry_write      (in_entry_write),
    .in_entry_execute    (in_entry_execute),
    .cfg_valid           (cfg_valid & cfg_ready),
    .cfg_tlb_limit       (cfg_tlb_limit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_physical_address(out_physical_address),
    .out_tlb_hit         (out_tlb_hit),
    .out_status          (out_status)
  );

endmodule
